// File: rtl/sorted_unique_key_table_defines.svh
// Assertion macros used by sorted_unique_key_table.sv.
`ifndef SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define SUKT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define SUKT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SUKT_ASSERT(lbl, prop, msg)
`define SUKT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/sukt_pkg.sv
package sukt_pkg;

    localparam int KEY_W = 37;
    localparam int PAY_W = 32;
    localparam int POS_W = 6;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_INSERT = 2'd1,
        K_UPDATE = 2'd2,
        K_DELETE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
    } cmd_t;

    typedef struct packed {
        status_t                status;
        logic [POS_W-1:0]       position;
        logic [PAY_W-1:0]       found_payload;
        logic [CNT_OUT_W-1:0]   entry_count;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_STEP,
        S_CHECK,
        S_UP,
        S_PUT,
        S_DOWN
    } state_t;

endpackage

// File: rtl/sukt_ram.sv
module sukt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sorted_unique_key_table.sv
// Sorted table of unique keys, each carrying one payload word.
// A command (cmd: kind, key, payload) is transferred at a rising edge with
// start high and busy low. busy stays high while the command is worked on.
// Its single result is shown on result for exactly one cycle with done high;
// the receiver cannot hold it off and must take it in that cycle.
// The table lives in one memory with a registered read. Binary search
// alternates S_SEARCH (read the midpoint) and S_STEP (compare and halve
// the range). S_CHECK then finishes a lookup, an update or a failed
// command; an insert moves later entries up one by one in S_UP and writes
// the new entry in S_PUT, and a delete moves later entries down one by one
// in S_DOWN. These entry moves through the single memory port pair are the
// long part of a command.
// busy drops together with done, so the next command may be transferred in
// the cycle its predecessor's result is shown.
// Reset empties the table (entry_count 0); the memory itself is not cleared.
`include "sorted_unique_key_table_defines.svh"

module sorted_unique_key_table
    import sukt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   cur_reg, cur_next;
    cmd_t               cmd_reg, cmd_next;
    result_t            result_reg, result_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             mem_rdata;

    logic [CNT_W-1:0]   mid_calc;
    logic [CNT_W-1:0]   cnt_dec;
    logic [CNT_W-1:0]   lo_inc;
    logic [CNT_W-1:0]   cur_inc;
    logic [CNT_W-1:0]   cur_dec;
    logic               hit;
    entry_t             new_entry;

    sukt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cnt_dec   = count_reg - 1'b1;
    assign lo_inc    = lo_reg + 1'b1;
    assign cur_inc   = cur_reg + 1'b1;
    assign cur_dec   = cur_reg - 1'b1;
    assign hit       = (lo_reg < count_reg) && (mem_rdata.key == cmd_reg.key);
    assign new_entry = '{key: cmd_reg.key, payload: cmd_reg.payload};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        cur_reg    <= cur_next;
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    // Entry moves are pipelined: the read of one entry is issued while the
    // entry read in the cycle before is written to its neighbor, so each entry
    // is read before its slot is overwritten.
    always_comb
    begin
        logic       finish;
        status_t    fin_status;
        logic [PAY_W-1:0] fin_payload;

        finish      = 1'b0;
        fin_status  = ST_OK;
        fin_payload = '0;

        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        cur_next    = cur_reg;
        cmd_next    = cmd_reg;
        result_next = result_reg;

        mem_we      = 1'b0;
        mem_waddr   = lo_reg[IDX_W-1:0];
        mem_wdata   = new_entry;
        mem_raddr   = lo_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_raddr  = mid_calc[IDX_W-1:0];
                    mid_next   = mid_calc;
                    state_next = S_STEP;
                end
                else
                begin
                    // Read the slot found; a slot at the end is gated by hit.
                    mem_raddr  = lo_reg[IDX_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_STEP:
            begin
                if (mem_rdata.key < cmd_reg.key)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SEARCH;
            end
            S_CHECK:
            begin
                unique case (cmd_reg.kind)
                    K_LOOKUP:
                    begin
                        finish = 1'b1;
                        if (hit)
                        begin
                            fin_status  = ST_OK;
                            fin_payload = mem_rdata.payload;
                        end
                        else
                        begin
                            fin_status = ST_NOT_FOUND;
                        end
                    end
                    K_INSERT:
                    begin
                        if (hit)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_DUPLICATE;
                        end
                        else if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            finish     = 1'b1;
                            fin_status = ST_FULL;
                        end
                        else if (count_reg == lo_reg)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            mem_raddr  = cnt_dec[IDX_W-1:0];
                            cur_next   = cnt_dec;
                            state_next = S_UP;
                        end
                    end
                    K_UPDATE:
                    begin
                        finish = 1'b1;
                        if (hit)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = lo_reg[IDX_W-1:0];
                            mem_wdata  = new_entry;
                            fin_status = ST_OK;
                        end
                        else
                        begin
                            fin_status = ST_NOT_FOUND;
                        end
                    end
                    K_DELETE:
                    begin
                        if (!hit)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_NOT_FOUND;
                        end
                        else if (lo_inc < count_reg)
                        begin
                            mem_raddr  = lo_inc[IDX_W-1:0];
                            cur_next   = lo_inc;
                            state_next = S_DOWN;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            fin_status = ST_OK;
                            count_next = cnt_dec;
                        end
                    end
                    default:
                    begin
                        finish     = 1'b1;
                        fin_status = ST_NOT_FOUND;
                    end
                endcase
            end
            S_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_inc[IDX_W-1:0];
                mem_wdata = mem_rdata;
                if (cur_reg == lo_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem_raddr = cur_dec[IDX_W-1:0];
                    cur_next  = cur_dec;
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg[IDX_W-1:0];
                mem_wdata  = new_entry;
                count_next = count_reg + 1'b1;
                finish     = 1'b1;
                fin_status = ST_OK;
            end
            S_DOWN:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_dec[IDX_W-1:0];
                mem_wdata = mem_rdata;
                if (cur_inc < count_reg)
                begin
                    mem_raddr = cur_inc[IDX_W-1:0];
                    cur_next  = cur_inc;
                end
                else
                begin
                    count_next = cnt_dec;
                    finish     = 1'b1;
                    fin_status = ST_OK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next                = S_IDLE;
            done_next                 = 1'b1;
            result_next.status        = fin_status;
            result_next.position      = (fin_status == ST_OK) ? POS_W'(lo_reg) : '0;
            result_next.found_payload = fin_payload;
            result_next.entry_count   = CNT_OUT_W'(count_next);
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `SUKT_ASSERT(a_count_in_range, count_reg <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
    `SUKT_ASSERT(a_done_when_idle, done_reg |-> !busy, "result shown while a command is still busy")
    `SUKT_ASSERT(a_count_moves_with_done, (count_reg != $past(count_reg)) |-> done_reg, "entry count changed without a result")
    `SUKT_ASSERT(a_fail_position_zero, (done_reg && (result_reg.status != ST_OK)) |-> (result_reg.position == '0), "failed command reports a nonzero position")
    `SUKT_ASSERT(a_insert_grows, (done_reg && (result_reg.status == ST_OK) && (cmd_reg.kind == K_INSERT)) |-> (count_reg == $past(count_reg) + 1'b1), "successful insert did not add one entry")
    `SUKT_ASSERT(a_search_bounds, (state_reg == S_SEARCH) |-> (lo_reg <= hi_reg), "binary search bounds crossed")

endmodule
